/* hw/rtl/pwc_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and the prbs31 word generator for the prbs31 word checker
// no dependencies; every other file of the block refers to this package by scoped names

package pwc_pkg;

	// number of receive channels with their own checker state
	localparam int CHANNELS = 2;

	// prbs31 generator: x^31 + x^28 + 1, seeded all ones
	localparam int LFSR_W = 31;
	localparam int WORD_W = 32;
	localparam logic [LFSR_W-1:0] LFSR_SEED = {LFSR_W{1'b1}};
	localparam int TAP_HI = 30;
	localparam int TAP_LO = 27;

	// reset value of the word limit register
	localparam logic [WORD_W-1:0] TOTAL_WORDS_RESET = 32'd16777216;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_WORDS = 2'd0,
		REG_LEFT_MASK   = 2'd1,
		REG_RIGHT_MASK  = 2'd2
	} cfg_reg_t;

	// alignment class given to a word by the front
	typedef enum logic [1:0] {
		ALIGN_NONE,
		ALIGN_LEFT,
		ALIGN_RIGHT,
		ALIGN_SKIP
	} align_mode_t;

	// input transaction
	typedef struct packed {
		logic              channel;
		logic [WORD_W-1:0] rx_word;
	} pwc_in_t;

	// result transaction
	typedef struct packed {
		logic              out_channel;
		logic              checked;
		logic              mismatch;
		logic [WORD_W-1:0] compared_word;
		logic [WORD_W-1:0] expected_word;
		logic [WORD_W-1:0] error_total;
		logic              first_error_seen;
		logic [WORD_W-1:0] first_error_at;
		logic [WORD_W-1:0] words_counted;
		logic              complete;
	} pwc_out_t;

	// classified word carried through the queue
	typedef struct packed {
		logic              channel;
		align_mode_t       mode;
		logic [WORD_W-1:0] rx_word;
	} pwc_item_t;

	// generator state after one word and the word produced
	typedef struct packed {
		logic [LFSR_W-1:0] state;
		logic [WORD_W-1:0] word;
	} prbs_step_t;

	// advance the generator 32 bits, first bit lands in the word msb
	function automatic prbs_step_t prbs_next(input logic [LFSR_W-1:0] seed);
		prbs_step_t r;
		logic [LFSR_W-1:0] s;
		logic [WORD_W-1:0] w;
		logic fb;
		s = seed;
		w = '0;
		for (int k = 0; k < WORD_W; k++) begin
			fb = s[TAP_HI] ^ s[TAP_LO];
			s = {s[LFSR_W-2:0], fb};
			w = {w[WORD_W-2:0], fb};
		end
		r.state = s;
		r.word = w;
		return r;
	endfunction

endpackage

/* hw/rtl/pwc_front.sv */
`timescale 1ns / 1ps
// front of the checker: configuration registers, input register and alignment classification
// depends on pwc_pkg

module pwc_front (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pwc_pkg::WORD_W-1:0]       cfg_data,
	// input transactions
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pwc_pkg::pwc_in_t                 in_data,
	// toward the queue
	output logic                             push,
	output pwc_pkg::pwc_item_t               push_item,
	input  logic                             q_full,
	// to the back
	output logic [pwc_pkg::WORD_W-1:0]       word_limit
);

	logic [pwc_pkg::WORD_W-1:0] word_limit_q;
	logic [1:0]                 left_mask_q;
	logic [1:0]                 right_mask_q;
	logic                       valid_s1;
	pwc_pkg::pwc_item_t         item_s1;
	pwc_pkg::pwc_item_t         item_cls;
	logic                       advance;
	logic                       in_range;
	logic                       right_sel;
	logic                       left_sel;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_limit_q <= pwc_pkg::TOTAL_WORDS_RESET;
			left_mask_q <= '0;
			right_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (pwc_pkg::cfg_reg_t'(cfg_index))
				pwc_pkg::REG_TOTAL_WORDS: word_limit_q <= cfg_data;
				pwc_pkg::REG_LEFT_MASK:   left_mask_q <= cfg_data[1:0];
				pwc_pkg::REG_RIGHT_MASK:  right_mask_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign word_limit = word_limit_q;

	// classify the incoming word; right alignment wins over left
	always_comb begin
		in_range = 32'(in_data.channel) < pwc_pkg::CHANNELS;
		right_sel = right_mask_q[in_data.channel];
		left_sel = left_mask_q[in_data.channel];
		item_cls.channel = in_data.channel;
		item_cls.rx_word = in_data.rx_word;
		if (!in_range)
			item_cls.mode = pwc_pkg::ALIGN_SKIP;
		else if (right_sel)
			item_cls.mode = pwc_pkg::ALIGN_RIGHT;
		else if (left_sel)
			item_cls.mode = pwc_pkg::ALIGN_LEFT;
		else
			item_cls.mode = pwc_pkg::ALIGN_NONE;
	end

	// input register; moves into the queue whenever the queue has room
	assign push = valid_s1 && !q_full;
	assign advance = !valid_s1 || !q_full;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= item_cls;
		end
	end

	assign push_item = item_s1;

endmodule

/* hw/rtl/pwc_queue.sv */
`timescale 1ns / 1ps
// short queue of classified words between front and back
// depends on pwc_pkg

module pwc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pwc_pkg::pwc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output pwc_pkg::pwc_item_t head
);

	pwc_pkg::pwc_item_t             entry_q [pwc_pkg::QUEUE_DEPTH];
	logic [pwc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pwc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pwc_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full = count_q == pwc_pkg::QCNT_W'(pwc_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push_item;
	end

endmodule

/* hw/rtl/pwc_back.sv */
`timescale 1ns / 1ps
// back of the checker: per-channel prbs31 state, compare and counters, result register
// depends on pwc_pkg

module pwc_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  pwc_pkg::pwc_item_t         head,
	output logic                       pop,
	input  logic [pwc_pkg::WORD_W-1:0] word_limit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output pwc_pkg::pwc_out_t          out_data
);

	localparam logic [pwc_pkg::WORD_W-1:0] ALL_ONES = '1;

	logic [pwc_pkg::LFSR_W-1:0] lfsr_q [pwc_pkg::CHANNELS];
	logic [pwc_pkg::WORD_W-1:0] prev_word_q [pwc_pkg::CHANNELS];
	logic                       prev_valid_q [pwc_pkg::CHANNELS];
	logic [pwc_pkg::WORD_W-1:0] word_count_q [pwc_pkg::CHANNELS];
	logic [pwc_pkg::WORD_W-1:0] error_count_q [pwc_pkg::CHANNELS];
	logic                       first_err_valid_q [pwc_pkg::CHANNELS];
	logic [pwc_pkg::WORD_W-1:0] first_err_index_q [pwc_pkg::CHANNELS];

	logic                       out_valid_q;
	pwc_pkg::pwc_out_t          out_q;

	logic                       c;
	logic                       skip;
	logic                       active;
	logic                       check;
	logic                       bad;
	logic [pwc_pkg::WORD_W-1:0] cmp;
	logic [pwc_pkg::WORD_W-1:0] cmp_raw;
	pwc_pkg::prbs_step_t        gen;
	logic [pwc_pkg::WORD_W-1:0] wc_nxt;
	logic [pwc_pkg::WORD_W-1:0] err_nxt;
	logic                       fev_nxt;
	logic [pwc_pkg::WORD_W-1:0] fei_nxt;
	logic                       prev_upd;
	pwc_pkg::pwc_out_t          res;

	// take a word when the result register is free or being drained
	assign pop = q_not_empty && (!out_valid_q || !out_stall);

	// alignment, compare and counter updates for the head word
	always_comb begin
		c = head.channel;
		skip = head.mode == pwc_pkg::ALIGN_SKIP;
		active = word_count_q[c] < word_limit;
		check = 1'b0;
		prev_upd = 1'b0;
		cmp_raw = head.rx_word;
		case (head.mode)
			pwc_pkg::ALIGN_RIGHT: begin
				check = active;
				prev_upd = active;
				cmp_raw = {prev_valid_q[c] & prev_word_q[c][0], head.rx_word[31:1]};
			end
			pwc_pkg::ALIGN_LEFT: begin
				check = active && prev_valid_q[c];
				prev_upd = 1'b1;
				cmp_raw = {prev_word_q[c][30:0], head.rx_word[31]};
			end
			pwc_pkg::ALIGN_NONE: begin
				check = active;
				cmp_raw = head.rx_word;
			end
			default: ;
		endcase
		gen = pwc_pkg::prbs_next(lfsr_q[c]);
		cmp = check ? cmp_raw : '0;
		bad = check && (cmp_raw != gen.word);
		err_nxt = (bad && error_count_q[c] != ALL_ONES) ? error_count_q[c] + 1'b1
			: error_count_q[c];
		fev_nxt = first_err_valid_q[c] || bad;
		fei_nxt = (bad && !first_err_valid_q[c]) ? word_count_q[c] : first_err_index_q[c];
		wc_nxt = check ? word_count_q[c] + 1'b1 : word_count_q[c];
	end

	// assemble the result; words for missing channels report only the channel
	always_comb begin
		res = '0;
		res.out_channel = c;
		if (!skip) begin
			res.checked = check;
			res.mismatch = bad;
			res.compared_word = cmp;
			res.expected_word = check ? gen.word : '0;
			res.error_total = err_nxt;
			res.first_error_seen = fev_nxt;
			res.first_error_at = fei_nxt;
			res.words_counted = wc_nxt;
			res.complete = wc_nxt == word_limit;
		end
	end

	// per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pwc_pkg::CHANNELS; i++) begin
				lfsr_q[i] <= pwc_pkg::LFSR_SEED;
				prev_word_q[i] <= '0;
				prev_valid_q[i] <= 1'b0;
				word_count_q[i] <= '0;
				error_count_q[i] <= '0;
				first_err_valid_q[i] <= 1'b0;
				first_err_index_q[i] <= '0;
			end
		end else if (pop && !skip) begin
			if (check)
				lfsr_q[c] <= gen.state;
			if (prev_upd) begin
				prev_word_q[c] <= head.rx_word;
				prev_valid_q[c] <= 1'b1;
			end
			word_count_q[c] <= wc_nxt;
			error_count_q[c] <= err_nxt;
			first_err_valid_q[c] <= fev_nxt;
			first_err_index_q[c] <= fei_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// a mismatch is only reported for a compared word
	a_mismatch_checked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.mismatch |-> out_q.checked)
		else $error("mismatch reported on a word that was not compared");

	// a mismatch leaves a nonzero error count and a latched first error
	a_mismatch_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.mismatch |-> out_q.error_total != '0 && out_q.first_error_seen)
		else $error("mismatch not reflected in error count or first error flag");

	// words that were not compared carry no compared or expected word
	a_unchecked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.checked |-> out_q.compared_word == '0
			&& out_q.expected_word == '0)
		else $error("unchecked word reports nonzero compare data");

	// a pending result is held while the receiver stalls
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("result changed while stalled");

endmodule

/* hw/rtl/prbs31_word_checker_unit.sv */
`timescale 1ns / 1ps
// top level of the prbs31 word checker: front, queue and back joined together
// depends on pwc_pkg, pwc_front, pwc_queue, pwc_back
//
// usage
//  in channel: in_valid / in_stall carry one received word (channel, rx_word) per
//  transaction. out channel: out_valid / out_stall carry one result per word, in order.
//  cfg channel: cfg_valid / cfg_ready write the word limit (index 0), left_align_mask
//  (index 1) and right_align_mask (index 2); other indexes are ignored. cfg_ready is
//  always high. write configuration only while no word is in flight.
//  path: a taken word lands in the input register, then a queue entry, then the
//  result register. throughput: one word per cycle while out_stall stays low, set by
//  the per-channel update in the back (32-bit prbs advance, compare and counters).
//  reset: every channel generator returns to the all-ones seed, counters and the
//  previous-word store clear, registers take their reset values; no clearing pass.
//  stall: a stalled result holds; the queue (four entries) and the input register
//  keep taking words until they fill, then in_stall rises.

module prbs31_word_checker_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwc_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pwc_pkg::pwc_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pwc_pkg::pwc_out_t             out_data
);

	logic                       push;
	pwc_pkg::pwc_item_t         push_item;
	logic                       q_full;
	logic                       q_not_empty;
	logic                       pop;
	pwc_pkg::pwc_item_t         head;
	logic [pwc_pkg::WORD_W-1:0] word_limit;

	// accept and classify
	pwc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.push        (push),
		.push_item   (push_item),
		.q_full      (q_full),
		.word_limit  (word_limit)
	);

	// decoupling queue
	pwc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// check and report
	pwc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.word_limit  (word_limit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

/* test/pwc_result_checker.sv */
`timescale 1ns / 1ps
// result checker for the prbs31 word checker: watches the cfg, in and out channels,
// keeps its own per-channel prbs31 state, predicts every result and compares it
// depends on pwc_pkg for the transaction types, register indexes and reset values

module pwc_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pwc_pkg::WORD_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  pwc_pkg::pwc_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  pwc_pkg::pwc_out_t             out_data,
	output int                            fail_count,
	output int                            pending
);

	localparam int NCH = pwc_pkg::CHANNELS;

	// copies of the configuration registers
	logic [31:0] total_cfg;
	logic [1:0]  left_cfg;
	logic [1:0]  right_cfg;

	// per-channel checker state
	logic [30:0] gen_state  [0:NCH-1];
	logic [31:0] last_word  [0:NCH-1];
	logic        primed     [0:NCH-1];
	logic [31:0] words_seen [0:NCH-1];
	logic [31:0] err_tally  [0:NCH-1];
	logic        err_seen   [0:NCH-1];
	logic [31:0] err_at     [0:NCH-1];

	// results owed by the block, oldest first
	pwc_pkg::pwc_out_t grade_q[$];
	pwc_pkg::pwc_out_t want;
	int fails_n;

	// grade one received word and advance that channel's state
	function automatic pwc_pkg::pwc_out_t grade_word(input pwc_pkg::pwc_in_t w);
		pwc_pkg::pwc_out_t r;
		logic        c;
		logic        use_r;
		logic        use_l;
		logic        live;
		logic        chk;
		logic        fb;
		logic [31:0] cmp;
		logic [31:0] gen_w;
		logic [30:0] st;
		r = '0;
		c = w.channel;
		r.out_channel = c;
		use_r = right_cfg[c];
		use_l = !use_r && left_cfg[c];
		live = words_seen[c] < total_cfg;
		chk = 1'b0;
		cmp = '0;
		gen_w = '0;
		if (use_r) begin
			// right shift, previous low bit on top once primed
			if (live) begin
				chk = 1'b1;
				cmp = {primed[c] ? last_word[c][0] : 1'b0, w.rx_word[31:1]};
				last_word[c] = w.rx_word;
				primed[c] = 1'b1;
			end
		end else if (use_l) begin
			// left join; the store follows the input even when finished
			if (primed[c] && live) begin
				chk = 1'b1;
				cmp = {last_word[c][30:0], w.rx_word[31]};
			end
			last_word[c] = w.rx_word;
			primed[c] = 1'b1;
		end else if (live) begin
			chk = 1'b1;
			cmp = w.rx_word;
		end
		if (chk) begin
			// 32 generator steps, first bit into the msb
			st = gen_state[c];
			for (int k = 0; k < 32; k++) begin
				fb = st[30] ^ st[27];
				st = {st[29:0], fb};
				gen_w = {gen_w[30:0], fb};
			end
			gen_state[c] = st;
			if (cmp != gen_w) begin
				r.mismatch = 1'b1;
				if (!err_seen[c]) begin
					err_seen[c] = 1'b1;
					err_at[c] = words_seen[c];
				end
				if (err_tally[c] != '1)
					err_tally[c] = err_tally[c] + 1;
			end
			words_seen[c] = words_seen[c] + 1;
		end
		r.checked = chk;
		r.compared_word = cmp;
		r.expected_word = gen_w;
		r.error_total = err_tally[c];
		r.first_error_seen = err_seen[c];
		r.first_error_at = err_at[c];
		r.words_counted = words_seen[c];
		r.complete = (words_seen[c] == total_cfg);
		return r;
	endfunction

	// print one field if it differs
	function automatic void show_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v)
			$display("  %s: expected %h, got %h", name, exp_v, got_v);
	endfunction

	// watch the channels: register writes, words taken, results delivered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_cfg = pwc_pkg::TOTAL_WORDS_RESET;
			left_cfg = '0;
			right_cfg = '0;
			for (int c = 0; c < NCH; c++) begin
				gen_state[c] = pwc_pkg::LFSR_SEED;
				last_word[c] = '0;
				primed[c] = 1'b0;
				words_seen[c] = '0;
				err_tally[c] = '0;
				err_seen[c] = 1'b0;
				err_at[c] = '0;
			end
			grade_q.delete();
			fails_n = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					pwc_pkg::REG_TOTAL_WORDS: total_cfg = cfg_data;
					pwc_pkg::REG_LEFT_MASK:   left_cfg = cfg_data[1:0];
					pwc_pkg::REG_RIGHT_MASK:  right_cfg = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				grade_q.push_back(grade_word(in_data));
			if (out_valid && !out_stall) begin
				if (grade_q.size() == 0) begin
					fails_n++;
					if (fails_n <= 10)
						$display("result with nothing owed, channel %0d",
							out_data.out_channel);
				end else begin
					want = grade_q.pop_front();
					if (out_data !== want) begin
						fails_n++;
						if (fails_n <= 10) begin
							$display("wrong result transaction on channel %0d at %0t",
								want.out_channel, $realtime);
							show_field("out_channel", 32'(want.out_channel),
								32'(out_data.out_channel));
							show_field("checked", 32'(want.checked), 32'(out_data.checked));
							show_field("mismatch", 32'(want.mismatch),
								32'(out_data.mismatch));
							show_field("compared_word", want.compared_word,
								out_data.compared_word);
							show_field("expected_word", want.expected_word,
								out_data.expected_word);
							show_field("error_total", want.error_total, out_data.error_total);
							show_field("first_error_seen", 32'(want.first_error_seen),
								32'(out_data.first_error_seen));
							show_field("first_error_at", want.first_error_at,
								out_data.first_error_at);
							show_field("words_counted", want.words_counted,
								out_data.words_counted);
							show_field("complete", 32'(want.complete),
								32'(out_data.complete));
						end
					end
				end
			end
			fail_count <= fails_n;
			pending <= grade_q.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// top of the prbs31 word checker testbench: clock, reset, register writes, word stimulus
// and receiver stalls; depends on pwc_pkg, prbs31_word_checker_unit and pwc_result_checker

module tb_top;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [pwc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pwc_pkg::WORD_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	pwc_pkg::pwc_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pwc_pkg::pwc_out_t out_data;
	int fail_count;
	int pending;

	// stimulus-side view of each channel, used to build well-aligned streams
	logic [30:0] stim_gen    [0:1];
	logic [31:0] stim_cnt    [0:1];
	logic        stim_primed [0:1];
	logic [31:0] stim_total;
	logic [1:0]  stim_left;
	logic [1:0]  stim_right;

	stall_style_t stall_style = STALL_NONE;
	int stall_left = 0;
	int idle_cycles = 0;

	prbs31_word_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	pwc_result_checker checker_u (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #1 clk = ~clk;

	// receiver stalls: a random style, chosen anew each time the random countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style <= stall_style_t'($urandom_range(3, 0));
			stall_left <= $urandom_range(200, 20);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_style)
			STALL_NONE:     out_stall <= 1'b0;
			STALL_LIGHT:    out_stall <= ($urandom_range(3, 0) == 0);
			STALL_HEAVY:    out_stall <= ($urandom_range(9, 0) < 7);
			default:        out_stall <= ((stall_left % 7) < 3);
		endcase
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one prbs31 word from a generator state, msb first
	function automatic logic [31:0] prbs32(input logic [30:0] s, output logic [30:0] s_next);
		logic [31:0] w;
		logic [30:0] r;
		r = s;
		for (int k = 0; k < 32; k++) begin
			w[31-k] = r[30] ^ r[27];
			r = {r[29:0], w[31-k]};
		end
		s_next = r;
		return w;
	endfunction

	// next word for a channel, laid out so that its alignment yields the prbs word
	function automatic logic [31:0] make_word(input logic ch);
		logic [30:0] s1;
		logic [30:0] s2;
		logic [31:0] p0;
		logic [31:0] p1;
		logic [31:0] w;
		logic use_r;
		logic use_l;
		logic live;
		logic lead;
		p0 = prbs32(stim_gen[ch], s1);
		p1 = prbs32(s1, s2);
		use_r = stim_right[ch];
		use_l = !use_r && stim_left[ch];
		live = stim_cnt[ch] < stim_total;
		lead = 1'($urandom_range(1, 0));
		if (use_r)
			w = {p0[30:0], p1[31]};
		else if (use_l)
			w = stim_primed[ch] ? {p0[0], p1[31:1]} : {lead, p0[31:1]};
		else
			w = p0;
		if (live && (!use_l || stim_primed[ch])) begin
			stim_gen[ch] = s1;
			stim_cnt[ch] = stim_cnt[ch] + 1;
		end
		if (use_l || (use_r && live))
			stim_primed[ch] = 1'b1;
		return w;
	endfunction

	// register write; the caller lowers cfg_valid after the last one
	task automatic write_reg(input logic [pwc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] total, input logic [1:0] lmask,
			input logic [1:0] rmask);
		write_reg(pwc_pkg::REG_TOTAL_WORDS, total);
		write_reg(pwc_pkg::REG_LEFT_MASK, {30'd0, lmask});
		write_reg(pwc_pkg::REG_RIGHT_MASK, {30'd0, rmask});
		cfg_valid <= 1'b0;
		stim_total = total;
		stim_left = lmask;
		stim_right = rmask;
	endtask

	// one word transaction, held until taken
	task automatic send_word(input logic ch, input logic [31:0] word);
		pwc_pkg::pwc_in_t t;
		t.channel = ch;
		t.rx_word = word;
		in_data <= t;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// hold off until every owed result has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// random bursts of mostly clean stream words with some corrupted ones
	task automatic run_phase(input int n_items);
		int sent;
		int burst;
		int gap;
		int roll;
		logic one_ch;
		logic ch;
		logic [31:0] w;
		sent = 0;
		while (sent < n_items) begin
			burst = $urandom_range(40, 1);
			one_ch = ($urandom_range(3, 0) == 0);
			ch = 1'($urandom_range(1, 0));
			for (int i = 0; i < burst && sent < n_items; i++) begin
				if (!one_ch)
					ch = 1'($urandom_range(1, 0));
				w = make_word(ch);
				roll = $urandom_range(99, 0);
				if (roll < 6)
					w = w ^ (32'h1 << $urandom_range(31, 0));
				else if (roll < 9)
					w = $urandom;
				send_word(ch, w);
				sent++;
				if (sent == n_items / 2)
					drain();
			end
			gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0)
				pause(gap);
		end
		drain();
	endtask

	// main sequence
	initial begin
		logic [31:0] w;
		logic [31:0] low_cnt;
		for (int c = 0; c < 2; c++) begin
			stim_gen[c] = pwc_pkg::LFSR_SEED;
			stim_cnt[c] = '0;
			stim_primed[c] = 1'b0;
		end
		stim_total = pwc_pkg::TOTAL_WORDS_RESET;
		stim_left = '0;
		stim_right = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero total: nothing is checked and both channels read complete
		set_config(32'd0, 2'b00, 2'b00);
		send_word(1'b0, make_word(1'b0));
		send_word(1'b1, 32'hFFFF_FFFF);
		drain();

		// short total, left on channel 0, both modes on channel 1 (right wins),
		// run past the end so both channels finish, plus a write to an unmapped index
		write_reg(REG_UNMAPPED, $urandom);
		set_config(32'd6, 2'b11, 2'b10);
		for (int i = 0; i < 16; i++) begin
			w = make_word(i[0]);
			if (i == 4)
				w = w ^ 32'h0000_0001;
			else if (i == 7 || i == 15)
				w = 32'hFFFF_FFFF;
			else if (i == 14)
				w = 32'h0000_0000;
			send_word(i[0], w);
		end
		drain();

		// random phases across register settings
		set_config(32'hFFFF_FFFF, 2'b00, 2'b00);
		run_phase(230);
		set_config(32'hFFFF_FFFF, 2'b11, 2'b00);
		run_phase(230);
		low_cnt = (stim_cnt[0] < stim_cnt[1]) ? stim_cnt[0] : stim_cnt[1];
		set_config(low_cnt + $urandom_range(60, 20), 2'($urandom_range(3, 0)),
			2'($urandom_range(3, 0)));
		run_phase(230);
		set_config(32'hFFFF_FFFF, 2'($urandom_range(3, 0)), 2'b11);
		run_phase(230);
		set_config(32'd1, 2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)));
		run_phase(20);
		set_config(32'h8000_0000 | $urandom, 2'($urandom_range(3, 0)),
			2'($urandom_range(3, 0)));
		run_phase(210);

		// let the pipeline settle, then the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
